// ===== rtl/artp_pkg.sv =====
// Shared constants, types and command/status structs for the reuse-time profiler.
`default_nettype none
package artp_pkg;
    localparam int unsigned DefBuckets   = 1024;
    localparam int unsigned DefWays      = 4;
    localparam int unsigned DefAddrWidth = 32;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [12:0] MAX13 = 13'h1FFF;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input transaction, issue bucket read
        logic update;    // compare ways, update totals, write back, load result
        logic clr_start; // reset totals, begin bucket sweep
        logic clr_step;  // clear one bucket row
    } artp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
    } artp_sts_t;
endpackage
`default_nettype wire

// ===== rtl/address_reuse_time_profiler.sv =====
// Top level of the address reuse-time profiler.
// Each read or write transaction first reads the bucket row of BUCKETS rows
// (WAYS slots each) from the single-port memory, then compares ways, updates the slot and
// totals and writes the row back; the next transaction is accepted when the result leaves.
// A clear transaction sweeps the valid bits one bucket per cycle. After reset the block
// runs the same sweep on its own with s_ready low and no result, so the table starts
// empty without a clear transaction.
`default_nettype none
module address_reuse_time_profiler
    import artp_pkg::*;
#(
    parameter int unsigned BUCKETS    = DefBuckets,
    parameter int unsigned WAYS       = DefWays,
    parameter int unsigned ADDR_WIDTH = DefAddrWidth
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [31:0] s_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_access_count,
    output logic [47:0]      m_stride_sum,
    output logic             m_entry_found,
    output logic             m_table_full,
    output logic [31:0]      m_entry_reads,
    output logic [31:0]      m_entry_writes,
    output logic [47:0]      m_any_reuse_sum,
    output logic [47:0]      m_read_reuse_sum,
    output logic [47:0]      m_write_reuse_sum,
    output logic [12:0]      m_entries_used
);
    artp_cmd_t cmd;
    artp_sts_t sts;

    artp_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action, .m_valid, .m_ready,
        .cmd, .sts
    );

    artp_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS), .ADDR_WIDTH(ADDR_WIDTH)) u_dp (
        .aclk, .aresetn, .cmd, .sts, .s_action, .s_address,
        .m_access_count, .m_stride_sum, .m_entry_found, .m_table_full,
        .m_entry_reads, .m_entry_writes, .m_any_reuse_sum, .m_read_reuse_sum,
        .m_write_reuse_sum, .m_entries_used
    );

    a_no_full_and_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_entry_found && m_table_full))
        else $error("found and full both set");
    a_full_zero_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_table_full) |-> (m_entry_reads == '0 && m_entry_writes == '0))
        else $error("full result carries slot counts");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted back to back");
endmodule
`default_nettype wire

// ===== rtl/artp_ctrl.sv =====
// Controller state machine: sequences access, update and clear sweep.
`default_nettype none
module artp_ctrl
    import artp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_action,
    output logic            m_valid,
    input  wire logic       m_ready,
    output artp_cmd_t       cmd,
    input  wire artp_sts_t  sts
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_UPD   = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;
    localparam logic [1:0] ST_INIT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       take, res_done;

    assign m_valid = m_valid_reg;
    // accept while a result waits only if it leaves this cycle
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign take    = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        res_done     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (s_action == ACT_CLEAR) begin
                        cmd.clr_start = 1'b1;
                        state_next    = ST_CLEAR;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                res_done   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    res_done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_INIT: begin
                // sweep valid bits after reset, no result
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = res_done ? 1'b1 : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/artp_dp.sv =====
// Datapath: bucket memory, way compare, saturating counters and result registers.
`default_nettype none
module artp_dp
    import artp_pkg::*;
#(
    parameter int unsigned BUCKETS    = DefBuckets,
    parameter int unsigned WAYS       = DefWays,
    parameter int unsigned ADDR_WIDTH = DefAddrWidth
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire artp_cmd_t   cmd,
    output artp_sts_t        sts,
    input  wire logic [1:0]  s_action,
    input  wire logic [31:0] s_address,
    output logic [31:0]      m_access_count,
    output logic [47:0]      m_stride_sum,
    output logic             m_entry_found,
    output logic             m_table_full,
    output logic [31:0]      m_entry_reads,
    output logic [31:0]      m_entry_writes,
    output logic [47:0]      m_any_reuse_sum,
    output logic [47:0]      m_read_reuse_sum,
    output logic [47:0]      m_write_reuse_sum,
    output logic [12:0]      m_entries_used
);
    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned AW = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] rd_cnt;
        logic [31:0] wr_cnt;
        logic [31:0] last_rd;
        logic [31:0] last_wr;
        logic [47:0] any_sum;
        logic [47:0] rd_sum;
        logic [47:0] wr_sum;
    } slot_t;
    typedef slot_t [WAYS-1:0] row_t;

    // one row per bucket; valid bits kept in a separate memory so clear is a row sweep
    row_t             data_mem [BUCKETS];
    logic [WAYS-1:0]  vld_mem  [BUCKETS];
    row_t             row_rd;
    logic [WAYS-1:0]  vld_rd;

    logic [1:0]  act_reg;
    logic [31:0] addr_reg;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [31:0] prev_reg, total_reg;
    logic [47:0] stride_reg;
    logic [12:0] stored_reg;
    logic [BW-1:0] clr_idx_reg;

    logic [31:0] addr_in;
    always_comb begin
        addr_in = '0;
        addr_in[AW-1:0] = s_address[AW-1:0];
    end
    // bucket index: modulo by power of two is a mask; otherwise a small reduction
    always_comb begin
        logic [63:0] q;
        logic [31:0] r;
        q = '0;
        r = '0;
        if ((BUCKETS & (BUCKETS - 1)) == 0) begin
            bkt_next = BW'(addr_in & 32'(BUCKETS - 1));
        end else begin
            q = (64'(addr_in) * 64'((64'd1 << 32) / BUCKETS)) >> 32;
            r = addr_in - 32'(q[31:0] * 32'(BUCKETS));
            if (r >= 32'(BUCKETS)) r = r - 32'(BUCKETS);
            bkt_next = BW'(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            row_rd <= data_mem[bkt_next];
            vld_rd <= vld_mem[bkt_next];
        end
    end

    // way compare and update
    logic [31:0] total_n, prev_n;
    logic [47:0] stride_n;
    logic [31:0] diff;
    logic [48:0] ssum;
    logic        found, hit_free, full_n;
    logic [WAYS-1:0] hit_oh, free_oh, sel_oh;
    slot_t       cur, upd;
    logic [31:0] last_any;
    logic [48:0] t_any, t_rd, t_wr;

    always_comb begin
        hit_oh  = '0;
        free_oh = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (vld_rd[w] && row_rd[w].addr == addr_reg && hit_oh == '0) hit_oh[w] = 1'b1;
            if (!vld_rd[w] && free_oh == '0) free_oh[w] = 1'b1;
        end
        found    = |hit_oh;
        hit_free = |free_oh;
        full_n   = !found && !hit_free;
        sel_oh   = found ? hit_oh : free_oh;
        cur      = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) cur = row_rd[w];
        end
        if (!found) cur = '0;
        cur.addr = addr_reg;

        diff = (addr_reg > prev_reg) ? addr_reg - prev_reg : prev_reg - addr_reg;
        ssum = {1'b0, stride_reg} + 49'(diff);
        stride_n = (prev_reg == '0) ? stride_reg : (ssum[48] ? MAX48 : ssum[47:0]);
        total_n  = (total_reg == MAX32) ? total_reg : total_reg + 32'd1;
        prev_n   = addr_reg;

        upd      = cur;
        last_any = (cur.last_rd > cur.last_wr) ? cur.last_rd : cur.last_wr;
        t_any    = {1'b0, cur.any_sum} + 49'(total_n - last_any);
        t_rd     = {1'b0, cur.rd_sum} + 49'(total_n - cur.last_rd);
        t_wr     = {1'b0, cur.wr_sum} + 49'(total_n - cur.last_wr);
        if (last_any != '0) upd.any_sum = t_any[48] ? MAX48 : t_any[47:0];
        if (act_reg == ACT_WRITE) begin
            upd.wr_cnt  = (cur.wr_cnt == MAX32) ? cur.wr_cnt : cur.wr_cnt + 32'd1;
            if (cur.last_wr != '0) upd.wr_sum = t_wr[48] ? MAX48 : t_wr[47:0];
            upd.last_wr = total_n;
        end else begin
            upd.rd_cnt  = (cur.rd_cnt == MAX32) ? cur.rd_cnt : cur.rd_cnt + 32'd1;
            if (cur.last_rd != '0) upd.rd_sum = t_rd[48] ? MAX48 : t_rd[47:0];
            upd.last_rd = total_n;
        end
    end

    logic nop;
    assign nop = (act_reg == ACT_NOP);

    // memory writes
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            vld_mem[clr_idx_reg] <= '0;
        end else if (cmd.update && !nop && !full_n) begin
            for (int w = 0; w < WAYS; w++) begin
                if (sel_oh[w]) data_mem[bkt_reg][w] <= upd;
            end
            vld_mem[bkt_reg] <= vld_rd | sel_oh;
        end
    end

    assign sts.clr_last = (clr_idx_reg == BW'(BUCKETS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_action;
            addr_reg <= addr_in;
            bkt_reg  <= bkt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            total_reg   <= '0;
            stride_reg  <= '0;
            stored_reg  <= '0;
            clr_idx_reg <= '0;
        end else if (cmd.clr_start) begin
            prev_reg    <= '0;
            total_reg   <= '0;
            stride_reg  <= '0;
            stored_reg  <= '0;
            clr_idx_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_idx_reg <= clr_idx_reg + BW'(1);
        end else if (cmd.update && !nop) begin
            prev_reg   <= prev_n;
            total_reg  <= total_n;
            stride_reg <= stride_n;
            if (!found && hit_free && stored_reg != MAX13) stored_reg <= stored_reg + 13'd1;
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (cmd.clr_start) begin
            m_access_count    <= '0;
            m_stride_sum      <= '0;
            m_entry_found     <= 1'b0;
            m_table_full      <= 1'b0;
            m_entry_reads     <= '0;
            m_entry_writes    <= '0;
            m_any_reuse_sum   <= '0;
            m_read_reuse_sum  <= '0;
            m_write_reuse_sum <= '0;
            m_entries_used    <= '0;
        end else if (cmd.update) begin
            m_access_count    <= nop ? total_reg : total_n;
            m_stride_sum      <= nop ? stride_reg : stride_n;
            m_entry_found     <= !nop && found;
            m_table_full      <= !nop && full_n;
            m_entry_reads     <= (nop || full_n) ? '0 : upd.rd_cnt;
            m_entry_writes    <= (nop || full_n) ? '0 : upd.wr_cnt;
            m_any_reuse_sum   <= (nop || full_n) ? '0 : upd.any_sum;
            m_read_reuse_sum  <= (nop || full_n) ? '0 : upd.rd_sum;
            m_write_reuse_sum <= (nop || full_n) ? '0 : upd.wr_sum;
            m_entries_used    <= (!nop && !found && hit_free && stored_reg != MAX13)
                                 ? stored_reg + 13'd1 : stored_reg;
        end
    end
endmodule
`default_nettype wire
